// ===== sv/oesm_pkg.sv =====
// shared types and constants of the octree empty-space map
`default_nettype none

package oesm_pkg;

	// default tree height, the volume side is 2^(height+1)
	localparam int TREE_HEIGHT_DEF = 4;

	// internal voxel coordinate width, covers a side of up to 256
	localparam int COORD_W = 8;

	// input command codes
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_VOXEL = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	// configuration register indexes
	typedef enum logic {
		REG_THRESHOLD   = 1'b0,
		REG_SAMPLE_TYPE = 1'b1
	} reg_idx_t;

	// sample encodings
	typedef enum logic [1:0] {
		SAMPLE_BYTE  = 2'd0,
		SAMPLE_SHORT = 2'd1,
		SAMPLE_FLOAT = 2'd2
	} sample_t;

	// operations handed from the front to the back
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_SET   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	// one classified item in the queue
	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [2:0]         level;
		logic               hit;
	} item_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		S_CLEAR  = 2'd0,
		S_IDLE   = 2'd1,
		S_WRITE  = 2'd2,
		S_ANSWER = 2'd3
	} state_t;

endpackage

`default_nettype wire

// ===== sv/octree_empty_space_map.sv =====
// Octree empty-space map: one occupancy bitmap per level, clear, voxel write and node query.
// A query answer shows on out_valid after passing a queue slot, the held item and the result register.
// Set and query each take the back end through a row read, then a write back or an answer, before the next item.
// A clear sweeps 2^(3*TREE_HEIGHT-3) rows (512 at the default), one row of every level a cycle.
// Reset starts the same sweep; the two-entry queue still accepts items while it runs.
// Control and config registers reset to zero; held item, result and queue slots have no reset.
`default_nettype none

module octree_empty_space_map #(
	parameter int TREE_HEIGHT = oesm_pkg::TREE_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [4:0]  coord_x,
	input  wire logic [4:0]  coord_y,
	input  wire logic [4:0]  coord_z,
	input  wire logic [2:0]  tree_level,
	input  wire logic [31:0] sample_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             node_empty,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	logic            push;
	logic            q_ready;
	logic            q_valid;
	logic            q_pop;
	oesm_pkg::item_t push_item;
	oesm_pkg::item_t q_item;

	// classify incoming items
	oesm_front #(
		.TREE_HEIGHT(TREE_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.tree_level   (tree_level),
		.sample_value (sample_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.q_ready      (q_ready),
		.push         (push),
		.push_item    (push_item)
	);

	// decoupling queue
	oesm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.ready     (q_ready),
		.valid     (q_valid),
		.head      (q_item),
		.pop       (q_pop)
	);

	// map memories and sequencer
	oesm_back #(
		.TREE_HEIGHT(TREE_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.node_empty (node_empty)
	);

endmodule

`default_nettype wire

// ===== sv/oesm_front.sv =====
// front end: accepts items, holds configuration, classifies commands
`default_nettype none

module oesm_front #(
	parameter int TREE_HEIGHT = oesm_pkg::TREE_HEIGHT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          command,
	input  wire logic [4:0]          coord_x,
	input  wire logic [4:0]          coord_y,
	input  wire logic [4:0]          coord_z,
	input  wire logic [2:0]          tree_level,
	input  wire logic [31:0]         sample_value,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [31:0]         cfg_wdata,
	input  wire logic                q_ready,
	output logic                     push,
	output oesm_pkg::item_t          push_item
);

	logic [31:0] threshold_q;
	logic [1:0]  sample_type_q;
	logic        accept;
	logic        exceeds;
	logic        voxel_in;
	logic        query_hit;
	logic        keep;

	// ieee ordering key, both zeros folded together
	function automatic logic [31:0] float_key(input logic [31:0] b);
		logic [31:0] z;
		z = (b[30:0] == 31'd0) ? 32'd0 : b;
		return z[31] ? ~z : (z | 32'h8000_0000);
	endfunction

	function automatic logic is_nan(input logic [31:0] b);
		return b[30:0] > 31'h7f80_0000;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= 32'd0;
			sample_type_q <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				oesm_pkg::REG_THRESHOLD:   threshold_q   <= cfg_wdata;
				oesm_pkg::REG_SAMPLE_TYPE: sample_type_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// sample against threshold in the configured encoding
	always_comb begin
		case (sample_type_q)
			oesm_pkg::SAMPLE_BYTE:  exceeds = {24'd0, sample_value[7:0]} > threshold_q;
			oesm_pkg::SAMPLE_SHORT: exceeds = $signed(sample_value[15:0]) >
				$signed(threshold_q[15:0]);
			oesm_pkg::SAMPLE_FLOAT: exceeds = !is_nan(sample_value) && !is_nan(threshold_q) &&
				(float_key(sample_value) > float_key(threshold_q));
			default:                exceeds = 1'b0;
		endcase
	end

	// range checks for voxels and queried nodes
	always_comb begin
		voxel_in  = ((32'(coord_x) >> (TREE_HEIGHT + 1)) == 32'd0) &&
			((32'(coord_y) >> (TREE_HEIGHT + 1)) == 32'd0) &&
			((32'(coord_z) >> (TREE_HEIGHT + 1)) == 32'd0);
		query_hit = (32'(tree_level) <= 32'(TREE_HEIGHT)) &&
			((coord_x >> tree_level) == 5'd0) &&
			((coord_y >> tree_level) == 5'd0) &&
			((coord_z >> tree_level) == 5'd0);
	end

	// classification into queue operations
	always_comb begin
		push_item.x     = oesm_pkg::COORD_W'(coord_x);
		push_item.y     = oesm_pkg::COORD_W'(coord_y);
		push_item.z     = oesm_pkg::COORD_W'(coord_z);
		push_item.level = tree_level;
		push_item.hit   = query_hit;
		case (command)
			oesm_pkg::CMD_CLEAR: begin
				push_item.op = oesm_pkg::OP_CLEAR;
				keep         = 1'b1;
			end
			oesm_pkg::CMD_VOXEL: begin
				push_item.op = oesm_pkg::OP_SET;
				keep         = voxel_in && exceeds;
			end
			oesm_pkg::CMD_QUERY: begin
				push_item.op = oesm_pkg::OP_QUERY;
				keep         = 1'b1;
			end
			default: begin
				push_item.op = oesm_pkg::OP_CLEAR;
				keep         = 1'b0;
			end
		endcase
	end

	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;
	assign push     = accept && keep;

endmodule

`default_nettype wire

// ===== sv/oesm_queue.sv =====
// two-entry queue between the front and the back
`default_nettype none

module oesm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire oesm_pkg::item_t push_item,
	output logic                 ready,
	output logic                 valid,
	output oesm_pkg::item_t      head,
	input  wire logic            pop
);

	localparam int QDEPTH = 2;
	localparam int PW     = $clog2(QDEPTH);

	oesm_pkg::item_t slot_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign ready = count_q != (PW+1)'(QDEPTH);
	assign valid = count_q != '0;
	assign head  = slot_q[rd_ptr_q];

	// storage slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== sv/oesm_back.sv =====
// back end: per-level occupancy memories, sequencer and result register
`default_nettype none

module oesm_back #(
	parameter int TREE_HEIGHT = oesm_pkg::TREE_HEIGHT_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire oesm_pkg::item_t q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 node_empty
);

	localparam int CW  = TREE_HEIGHT + 1;
	localparam int LW  = 3 * TREE_HEIGHT + 3;
	localparam int CLW = (TREE_HEIGHT <= 1) ? 1 : 3 * TREE_HEIGHT - 3;

	oesm_pkg::state_t state_q;
	oesm_pkg::state_t state_d;
	oesm_pkg::item_t  cur_q;
	oesm_pkg::item_t  src;
	logic [CLW-1:0]   clr_cnt_q;
	logic             out_valid_q;
	logic             node_empty_q;
	logic             clearing;
	logic             mem_we;
	logic             answer;
	logic [TREE_HEIGHT:0] occ;

	// address source: queue head while idle, held item otherwise
	assign src = (state_q == oesm_pkg::S_IDLE) ? q_item : cur_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			oesm_pkg::S_CLEAR: begin
				if (&clr_cnt_q) begin
					state_d = oesm_pkg::S_IDLE;
				end
			end
			oesm_pkg::S_IDLE: begin
				if (q_pop) begin
					case (q_item.op)
						oesm_pkg::OP_CLEAR: state_d = oesm_pkg::S_CLEAR;
						oesm_pkg::OP_SET:   state_d = oesm_pkg::S_WRITE;
						oesm_pkg::OP_QUERY: state_d = oesm_pkg::S_ANSWER;
						default:            state_d = oesm_pkg::S_IDLE;
					endcase
				end
			end
			oesm_pkg::S_WRITE:  state_d = oesm_pkg::S_IDLE;
			oesm_pkg::S_ANSWER: state_d = oesm_pkg::S_IDLE;
			default:            state_d = oesm_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs; a query leaves only with room in the result register
	always_comb begin
		q_pop    = 1'b0;
		clearing = 1'b0;
		mem_we   = 1'b0;
		answer   = 1'b0;
		case (state_q)
			oesm_pkg::S_CLEAR: begin
				clearing = 1'b1;
				mem_we   = 1'b1;
			end
			oesm_pkg::S_IDLE: begin
				q_pop = q_valid && ((q_item.op != oesm_pkg::OP_QUERY) ||
					!out_valid_q || out_ready);
			end
			oesm_pkg::S_WRITE:  mem_we = 1'b1;
			oesm_pkg::S_ANSWER: answer = 1'b1;
			default: ;
		endcase
	end

	// state, sweep counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oesm_pkg::S_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + CLW'(1);
			end
			if (answer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// held item and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (answer) begin
			node_empty_q <= !cur_q.hit || !(|occ);
		end
	end

	// one memory of eight-node rows per level, read then written back for a set
	for (genvar L = 0; L <= TREE_HEIGHT; L++) begin : g_level
		localparam int RW = (L <= 1) ? 1 : 3 * L - 3;
		localparam int SH = TREE_HEIGHT + 1 - L;

		logic [CW-1:0] nx;
		logic [CW-1:0] ny;
		logic [CW-1:0] nz;
		logic [LW-1:0] lidx;
		logic [RW-1:0] row;
		logic [RW-1:0] waddr;
		logic [2:0]    bitn;
		logic [7:0]    wdata;
		logic [7:0]    rd_q;
		logic [7:0]    mem [1 << RW];

		// node coordinates at this level and row address
		always_comb begin
			if (src.op == oesm_pkg::OP_QUERY) begin
				nx = CW'(src.x);
				ny = CW'(src.y);
				nz = CW'(src.z);
			end else begin
				nx = CW'(src.x) >> SH;
				ny = CW'(src.y) >> SH;
				nz = CW'(src.z) >> SH;
			end
			lidx  = (LW'(nz) << (2 * L)) | (LW'(ny) << L) | LW'(nx);
			row   = RW'(lidx >> 3);
			bitn  = lidx[2:0];
			waddr = clearing ? RW'(clr_cnt_q) : row;
			wdata = clearing ? 8'h00 : (rd_q | (8'h01 << bitn));
		end

		always_ff @(posedge clk) begin
			if (mem_we) begin
				mem[waddr] <= wdata;
			end
			if (q_pop) begin
				rd_q <= mem[row];
			end
		end

		assign occ[L] = rd_q[bitn] && (cur_q.level == 3'(L));
	end

	assign out_valid  = out_valid_q;
	assign node_empty = node_empty_q;

endmodule

`default_nettype wire

// ===== sv/oesm_checker.sv =====
// port-level checks of the octree empty-space map and their binding
`default_nettype none

module oesm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] command,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       node_empty
);

	logic [2:0] pending_q;
	logic       q_in;
	logic       q_out;

	assign q_in  = in_valid && in_ready && (command == oesm_pkg::CMD_QUERY);
	assign q_out = out_valid && out_ready;

	// queries accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + 3'(q_in) - 3'(q_out);
		end
	end

	// a stalled answer holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(node_empty))
		else $error("answer changed while stalled");

	// no answer without an outstanding query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("answer without a pending query");

	// queue plus held item plus result register bound the queries in flight
	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many queries in flight");

endmodule

bind octree_empty_space_map oesm_checker u_oesm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.command    (command),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.node_empty (node_empty)
);

`default_nettype wire
